// File: rtl/core/rrlt_pkg.sv
// Shared types and constants of the row-run line tracker.
package rrlt_pkg;

  localparam int COL_W      = 10;
  localparam int ROW_W      = 10;
  localparam int LEN_W      = 11;
  localparam int MID_W      = 11;
  localparam int LSUM_W     = 21;
  localparam int MASK_W     = 16;
  localparam int NT_W       = 4;
  localparam int ROW_WIDTH  = 1024;
  localparam int LEN_CAP    = (ROW_WIDTH < 2047) ? ROW_WIDTH : 2047;
  localparam int DIV_STEPS  = LSUM_W;
  localparam int DCNT_W     = $clog2(DIV_STEPS + 1);

  localparam logic [LEN_W-1:0]  MIN_LEN_RST = LEN_W'(10);
  localparam logic [LEN_W-1:0]  COUNT_MAX   = {LEN_W{1'b1}};
  localparam logic [LSUM_W:0]   SUM_MAX     = {1'b0, {LSUM_W{1'b1}}};

  localparam int MAX_TRACKS_DEF       = 16;
  localparam int MIDPOINT_HISTORY_DEF = 10;

  typedef struct packed {
    logic [7:0]       pixel;
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row_index;
    logic             row_end;
    logic             frame_start;
  } in_t;

  typedef struct packed {
    logic [COL_W-1:0]  segment_start;
    logic [ROW_W-1:0]  segment_row;
    logic [LEN_W-1:0]  segment_length;
    logic [MASK_W-1:0] joined_mask;
    logic              created_new;
    logic [NT_W-1:0]   new_track;
    logic              table_full;
  } out_t;

  typedef struct packed {
    logic [COL_W-1:0] start;
    logic [LEN_W-1:0] length;
  } seg_t;

  typedef struct packed {
    logic clear;
    logic div_start;
    logic div_step;
    logic commit;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DIV,
    ST_DECIDE
  } st_t;

endpackage

// File: rtl/core/rrlt_div.sv
// Restoring divider that produces one quotient bit per step.
module rrlt_div #(
  parameter int DW = 21,
  parameter int VW = 11
) (
  input  logic          clk,
  input  logic          start,
  input  logic          step,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic [DW-1:0] quotient
);
  logic [VW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [VW:0]   rem_sh;

  always_comb begin
    rem_sh  = {rem_r, quo_r[DW-1]};
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    if (start) begin
      rem_nxt = '0;
      quo_nxt = dividend;
    end else if (step) begin
      if (rem_sh >= {1'b0, divisor}) begin
        rem_nxt = VW'(rem_sh - {1'b0, divisor});
        quo_nxt = {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[VW-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign quotient = quo_r;
endmodule

// File: rtl/core/rrlt_cell.sv
// One track cell: track state, midpoint history, means and the join test.
module rrlt_cell #(
  parameter int MIDPOINT_HISTORY = rrlt_pkg::MIDPOINT_HISTORY_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rrlt_pkg::cell_ctl_t ctl,
  input  rrlt_pkg::seg_t      seg,
  input  logic                open,
  input  logic                hit_in,
  output logic                hit,
  output logic                hit_out,
  output logic                valid
);
  import rrlt_pkg::*;

  localparam int SLOT_W = (MIDPOINT_HISTORY > 1) ? $clog2(MIDPOINT_HISTORY) : 1;
  localparam int FILL_W = $clog2(MIDPOINT_HISTORY + 1);
  localparam int MSUM_W = $clog2(MIDPOINT_HISTORY * 2047 + 1);

  logic               valid_r;
  logic [COL_W-1:0]   last_start_r;
  logic [LEN_W-1:0]   last_len_r;
  logic [MID_W-1:0]   hist_r [MIDPOINT_HISTORY];
  logic [MIDPOINT_HISTORY-1:0] full_r;
  logic [SLOT_W-1:0]  slot_r;
  logic [FILL_W-1:0]  fill_r;
  logic [MSUM_W-1:0]  msum_r;
  logic [LSUM_W-1:0]  lsum_r;
  logic [LEN_W-1:0]   cnt_r;

  logic [LSUM_W-1:0]  mid_q, len_q;
  logic [MID_W-1:0]   new_mid, old_mid;
  logic               add_en, sum_ok, overlap, in_range;
  logic [LSUM_W:0]    lsum_try;
  logic [12:0]        x_w, m_w, a_w;

  rrlt_div #(.DW(LSUM_W), .VW(FILL_W)) u_mid_div (
    .clk(clk), .start(ctl.div_start), .step(ctl.div_step),
    .dividend(LSUM_W'(msum_r)), .divisor(fill_r), .quotient(mid_q)
  );

  rrlt_div #(.DW(LSUM_W), .VW(LEN_W)) u_len_div (
    .clk(clk), .start(ctl.div_start), .step(ctl.div_step),
    .dividend(lsum_r), .divisor(cnt_r), .quotient(len_q)
  );

  always_comb begin
    if (last_start_r <= seg.start) begin
      overlap = ({2'b0, seg.start} <= ({2'b0, last_start_r} + {1'b0, last_len_r}));
    end else begin
      overlap = ({2'b0, last_start_r} <= ({2'b0, seg.start} + {1'b0, seg.length}));
    end
    x_w      = {3'b0, seg.start};
    m_w      = {2'b0, mid_q[MID_W-1:0]};
    a_w      = {2'b0, len_q[LEN_W-1:0]};
    in_range = ((x_w + a_w) >= m_w) && (x_w <= (m_w + a_w));
    hit      = valid_r && overlap && in_range;
  end

  assign hit_out = hit_in | hit;
  assign valid   = valid_r;
  assign add_en  = ctl.commit && (hit || open);
  assign new_mid = MID_W'({1'b0, seg.start} + (seg.length >> 1));
  assign old_mid = full_r[slot_r] ? hist_r[slot_r] : '0;
  assign lsum_try = {1'b0, lsum_r} + (LSUM_W + 1)'(seg.length);
  assign sum_ok  = (cnt_r < COUNT_MAX) && (lsum_try <= SUM_MAX);

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      valid_r <= 1'b0;
      full_r  <= '0;
      slot_r  <= '0;
      fill_r  <= '0;
      msum_r  <= '0;
      lsum_r  <= '0;
      cnt_r   <= '0;
    end else if (add_en) begin
      valid_r        <= 1'b1;
      full_r[slot_r] <= 1'b1;
      slot_r <= (slot_r == SLOT_W'(MIDPOINT_HISTORY - 1)) ? '0 : SLOT_W'(slot_r + 1'b1);
      if (fill_r != FILL_W'(MIDPOINT_HISTORY)) begin
        fill_r <= FILL_W'(fill_r + 1'b1);
      end
      msum_r <= MSUM_W'(msum_r - MSUM_W'(old_mid) + MSUM_W'(new_mid));
      if (sum_ok) begin
        lsum_r <= lsum_try[LSUM_W-1:0];
        cnt_r  <= LEN_W'(cnt_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (add_en) begin
      last_start_r   <= seg.start;
      last_len_r     <= seg.length;
      hist_r[slot_r] <= new_mid;
    end
  end
endmodule

// File: rtl/core/row_run_line_tracker.sv
// Top level of the row-run line tracker: run detection, control and track cells.
// Pixels are taken one per cycle while in_stall is low. A pixel that ends a run at
// least min_segment_length long holds the input off: first every track cell runs
// its two bit-serial dividers (mean midpoint and mean run length, one quotient bit
// per cycle over the 21-bit length sum), then the cells decide, the result beat is
// registered and the joined or newly opened tracks are updated. That last step
// waits while an earlier result beat is still stalled. A frame start clears all
// tracks at once.
module row_run_line_tracker #(
  parameter int MAX_TRACKS       = rrlt_pkg::MAX_TRACKS_DEF,
  parameter int MIDPOINT_HISTORY = rrlt_pkg::MIDPOINT_HISTORY_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  rrlt_pkg::in_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output rrlt_pkg::out_t                out_data,
  input  logic                          cfg_wr_en,
  input  logic [rrlt_pkg::LEN_W-1:0]    cfg_wr_data
);
  import rrlt_pkg::*;

  localparam int TU_W = $clog2(MAX_TRACKS + 1);
  localparam int MSHOW = (MAX_TRACKS < MASK_W) ? MAX_TRACKS : MASK_W;

  st_t              st_r, st_nxt;
  logic [DCNT_W-1:0] dcnt_r, dcnt_nxt;
  logic [LEN_W-1:0] min_len_r;
  logic             run_act_r, run_act_nxt;
  logic [COL_W-1:0] run_start_r, run_start_nxt;
  logic [LEN_W-1:0] run_len_r, run_len_nxt;
  seg_t             seg_r, seg_nxt;
  logic [ROW_W-1:0] seg_row_r, seg_row_nxt;
  logic [TU_W-1:0]  used_r, used_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_data_r, out_data_nxt;

  logic             in_acc, out_free, emit;
  logic             act_c, white, finish;
  logic [COL_W-1:0] start_c, fin_start;
  logic [LEN_W-1:0] len_c, fin_len;
  cell_ctl_t        ctl;
  logic [MAX_TRACKS:0]   hit_chain;
  logic [MAX_TRACKS-1:0] hit_w, open_w, valid_w;
  logic [MASK_W-1:0]     mask_w;
  logic             joined;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign joined   = hit_chain[MAX_TRACKS];

  // Run detection for the accepted pixel, after any frame-start clear.
  always_comb begin
    act_c   = run_act_r && !in_data.frame_start;
    start_c = in_data.frame_start ? '0 : run_start_r;
    len_c   = in_data.frame_start ? '0 : run_len_r;
    white   = (in_data.pixel != '0);
    fin_start = start_c;
    fin_len   = len_c;
    if (white) begin
      if (!act_c) begin
        fin_start = in_data.column;
        fin_len   = LEN_W'(1);
      end else if (len_c < LEN_W'(LEN_CAP)) begin
        fin_len = LEN_W'(len_c + 1'b1);
      end
      finish = in_data.row_end;
    end else begin
      finish = act_c;
    end
    emit = in_acc && finish && (fin_len >= min_len_r);
  end

  always_comb begin
    st_nxt        = st_r;
    dcnt_nxt      = dcnt_r;
    run_act_nxt   = run_act_r;
    run_start_nxt = run_start_r;
    run_len_nxt   = run_len_r;
    seg_nxt       = seg_r;
    seg_row_nxt   = seg_row_r;
    used_nxt      = used_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    in_stall      = (st_r != ST_RUN);
    ctl           = '0;
    open_w        = '0;
    unique case (st_r)
      ST_RUN: begin
        if (in_acc) begin
          ctl.clear = in_data.frame_start;
          if (in_data.frame_start) begin
            used_nxt = '0;
          end
          if (finish) begin
            run_act_nxt   = 1'b0;
            run_start_nxt = '0;
            run_len_nxt   = '0;
          end else begin
            run_act_nxt   = white || act_c;
            run_start_nxt = fin_start;
            run_len_nxt   = fin_len;
          end
          if (emit) begin
            seg_nxt.start  = fin_start;
            seg_nxt.length = fin_len;
            seg_row_nxt    = in_data.row_index;
            dcnt_nxt       = '0;
            st_nxt         = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        ctl.div_start = (dcnt_r == '0);
        ctl.div_step  = (dcnt_r != '0);
        dcnt_nxt      = DCNT_W'(dcnt_r + 1'b1);
        if (dcnt_r == DCNT_W'(DIV_STEPS)) begin
          st_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (out_free) begin
          ctl.commit = 1'b1;
          out_data_nxt.segment_start  = seg_r.start;
          out_data_nxt.segment_row    = seg_row_r;
          out_data_nxt.segment_length = seg_r.length;
          out_data_nxt.joined_mask    = mask_w;
          out_data_nxt.created_new    = 1'b0;
          out_data_nxt.new_track      = '0;
          out_data_nxt.table_full     = 1'b0;
          if (!joined) begin
            if (used_r < TU_W'(MAX_TRACKS)) begin
              for (int i = 0; i < MAX_TRACKS; i++) begin
                open_w[i] = (used_r == TU_W'(i));
              end
              out_data_nxt.created_new = 1'b1;
              out_data_nxt.new_track   = NT_W'(used_r);
              used_nxt = TU_W'(used_r + 1'b1);
            end else begin
              out_data_nxt.table_full = 1'b1;
            end
          end
          out_valid_nxt = 1'b1;
          st_nxt        = ST_RUN;
        end
      end
      default: st_nxt = ST_RUN;
    endcase
  end

  always_comb begin
    mask_w = '0;
    for (int i = 0; i < MSHOW; i++) begin
      mask_w[i] = hit_w[i];
    end
  end

  assign hit_chain[0] = 1'b0;

  for (genvar g = 0; g < MAX_TRACKS; g++) begin : g_cell
    rrlt_cell #(.MIDPOINT_HISTORY(MIDPOINT_HISTORY)) u_cell (
      .clk(clk), .rst_n(rst_n), .ctl(ctl), .seg(seg_r), .open(open_w[g]),
      .hit_in(hit_chain[g]), .hit(hit_w[g]), .hit_out(hit_chain[g+1]),
      .valid(valid_w[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_RUN;
      dcnt_r      <= '0;
      min_len_r   <= MIN_LEN_RST;
      run_act_r   <= 1'b0;
      run_start_r <= '0;
      run_len_r   <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      dcnt_r      <= dcnt_nxt;
      run_act_r   <= run_act_nxt;
      run_start_r <= run_start_nxt;
      run_len_r   <= run_len_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        min_len_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    seg_r      <= seg_nxt;
    seg_row_r  <= seg_row_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= TU_W'(MAX_TRACKS))
    else $error("track count beyond table size");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_data_r))
    else $error("stalled result beat changed or dropped");

  a_rose_decide: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.commit |=> out_valid_r && st_r == ST_RUN)
    else $error("commit did not produce a result beat");

  a_full_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.created_new && out_data_r.table_full))
    else $error("opened a track and flagged a full table together");

  a_join_excl: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.commit && joined |-> open_w == '0)
    else $error("track opened for a joined segment");

  a_used_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.commit && !joined && used_r < TU_W'(MAX_TRACKS) |=> valid_w != '0)
    else $error("opened track not marked valid");
endmodule

// File: bench/row_run_line_tracker_tb.sv
// Self-checking testbench of the row-run line tracker: directed rows, random frames, pressure.
module row_run_line_tracker_tb;
  import rrlt_pkg::*;

  localparam int NTRK = MAX_TRACKS_DEF;
  localparam int NHIST = MIDPOINT_HISTORY_DEF;
  localparam int CYCLE_LIMIT = 900000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_wr_en = 1'b0;
  logic [LEN_W-1:0] cfg_wr_data = '0;

  row_run_line_tracker u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  // Predicted tracker state.
  int unsigned min_len;
  bit pr_active;
  int unsigned pr_start, pr_len;
  bit trk_valid [NTRK];
  int unsigned trk_start [NTRK], trk_len [NTRK], trk_slot [NTRK];
  int unsigned trk_sum [NTRK], trk_cnt [NTRK];
  int unsigned mid_val [NTRK][NHIST];
  bit mid_full [NTRK][NHIST];
  int unsigned trk_used;

  out_t segments_due [$];
  int unsigned n_errors = 0, n_segments = 0, n_pixels = 0, n_full = 0;
  longint unsigned cycle_count = 0;
  bit hold_off = 1'b0;

  initial forever #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  function automatic void clear_tracks();
    for (int t = 0; t < NTRK; t++) begin
      trk_valid[t] = 0; trk_start[t] = 0; trk_len[t] = 0; trk_slot[t] = 0;
      trk_sum[t] = 0; trk_cnt[t] = 0;
      for (int i = 0; i < NHIST; i++) begin
        mid_val[t][i] = 0; mid_full[t][i] = 0;
      end
    end
    trk_used = 0;
  endfunction

  function automatic void append_segment(int t, int unsigned s0, int unsigned l0);
    int unsigned s;
    s = trk_slot[t];
    if (s >= NHIST) s = 0;
    trk_start[t] = s0;
    trk_len[t] = l0;
    mid_val[t][s] = (s0 + l0 / 2) & 'h7ff;
    mid_full[t][s] = 1;
    s++;
    trk_slot[t] = (s >= NHIST) ? 0 : s;
    if (trk_cnt[t] < 2047 && trk_sum[t] + l0 <= 2097151) begin
      trk_sum[t] += l0;
      trk_cnt[t]++;
    end
  endfunction

  function automatic out_t associate_segment(int unsigned row);
    out_t r;
    int m, a, n;
    int unsigned sum;
    bit ov, joined;
    r = '0;
    joined = 0;
    for (int t = 0; t < NTRK; t++) begin
      if (!trk_valid[t]) continue;
      if (trk_start[t] <= pr_start) ov = pr_start <= trk_start[t] + trk_len[t];
      else ov = trk_start[t] <= pr_start + pr_len;
      if (!ov) continue;
      sum = 0; n = 0;
      for (int i = 0; i < NHIST; i++)
        if (mid_full[t][i]) begin
          sum += mid_val[t][i]; n++;
        end
      m = (n == 0) ? 0 : int'(sum / n);
      a = (trk_cnt[t] == 0) ? 0 : int'(trk_sum[t] / trk_cnt[t]);
      if (int'(pr_start) >= m - a && int'(pr_start) <= m + a) begin
        append_segment(t, pr_start, pr_len);
        joined = 1;
        r.joined_mask[t] = 1'b1;
      end
    end
    r.segment_start = COL_W'(pr_start);
    r.segment_row = ROW_W'(row);
    r.segment_length = LEN_W'(pr_len);
    if (!joined) begin
      if (trk_used < NTRK) begin
        trk_valid[trk_used] = 1;
        append_segment(trk_used, pr_start, pr_len);
        r.created_new = 1'b1;
        r.new_track = NT_W'(trk_used);
        trk_used++;
      end else begin
        r.table_full = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic void predict_pixel(in_t p);
    bit fin;
    fin = 0;
    if (p.frame_start) begin
      clear_tracks();
      pr_active = 0; pr_start = 0; pr_len = 0;
    end
    if (p.pixel != 0) begin
      if (!pr_active) begin
        pr_active = 1; pr_start = p.column; pr_len = 1;
      end else if (pr_len < LEN_CAP) begin
        pr_len++;
      end
      if (p.row_end) fin = 1;
    end else if (pr_active) begin
      fin = 1;
    end
    if (fin) begin
      if (pr_len >= min_len) begin
        segments_due.insert(segments_due.size(), associate_segment(p.row_index));
      end
      pr_active = 0; pr_start = 0; pr_len = 0;
    end
  endfunction

  // Result checker.
  always @(posedge clk) begin
    out_t exp_seg;
    if (rst_n && out_valid && !out_stall) begin
      if (segments_due.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected segment beat %p", out_data);
      end else begin
        exp_seg = segments_due.pop_front();
        n_segments++;
        if (exp_seg.table_full) n_full++;
        if (out_data !== exp_seg) begin
          n_errors++;
          if (n_errors <= 10) $display("segment mismatch: expected %p, got %p", exp_seg, out_data);
        end
      end
    end
  end

  // Receiver: a random wait before each result beat.
  initial begin
    int w;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
      end else begin
        w = $urandom_range(0, 4);
        if (w != 0) begin
          out_stall <= 1'b1;
          repeat (w) @(negedge clk);
        end
        out_stall <= 1'b0;
        @(posedge clk);
        while (!(out_valid && !out_stall) && !hold_off) @(posedge clk);
      end
    end
  end

  // Valid stays high after a beat unless the next one waits; idle callers drop it.
  task automatic send_pixel(in_t p);
    int gap;
    gap = $urandom_range(0, 4);
    if ($urandom_range(0, 2) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_pixel(p);
    n_pixels++;
    @(negedge clk);
  endtask

  task automatic write_min_len(int unsigned v);
    int guard;
    in_valid <= 1'b0;
    guard = 0;
    while (segments_due.size() != 0 && guard < 20000) begin
      @(negedge clk); guard++;
    end
    repeat (40) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= LEN_W'(v);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    min_len = v;
  endtask

  // One row: a run of given length at a given start, ending on row_end.
  task automatic send_row(int unsigned row, int unsigned first, int unsigned last,
                          int unsigned run_s, int unsigned run_l, bit fs);
    in_t p;
    for (int unsigned c = first; c <= last; c++) begin
      p.pixel = (c >= run_s && c < run_s + run_l) ? 8'($urandom_range(1, 255)) : 8'd0;
      p.column = COL_W'(c);
      p.row_index = ROW_W'(row);
      p.row_end = (c == last);
      p.frame_start = fs && (c == first);
      send_pixel(p);
    end
  endtask

  task automatic test_directed();
    in_t p;
    // Field extremes, a frame start cutting a run, and a run closed by row end.
    p = '{pixel: 8'hff, column: 10'h3ff, row_index: 10'h3ff, row_end: 1'b0, frame_start: 1'b1};
    send_pixel(p);
    write_min_len(1);
    p = '{pixel: 8'h01, column: 10'd0, row_index: 10'd0, row_end: 1'b1, frame_start: 1'b1};
    send_pixel(p);
    p = '{pixel: 8'h80, column: 10'd0, row_index: 10'd1, row_end: 1'b1, frame_start: 1'b0};
    send_pixel(p);
    p = '{pixel: 8'h00, column: 10'd5, row_index: 10'd2, row_end: 1'b1, frame_start: 1'b0};
    send_pixel(p);
    send_row(3, 0, 9, 2, 5, 1'b0);
    send_row(4, 0, 9, 3, 7, 1'b0);
    write_min_len(0);
    send_row(5, 0, 3, 1, 1, 1'b0);
    p = '{pixel: 8'h00, column: 10'd0, row_index: 10'd6, row_end: 1'b0, frame_start: 1'b1};
    send_pixel(p);
  endtask

  // Eighteen disjoint single-pixel segments fill the table and overflow it.
  task automatic test_table_full();
    write_min_len(1);
    send_row(10, 0, 0, 0, 0, 1'b1);
    for (int k = 0; k < NTRK + 2; k++) send_row(11, 40 * k, 40 * k + 2, 40 * k + 1, 1, 1'b0);
  endtask

  // A white run longer than the row saturates the run length at 1024.
  task automatic test_long_run();
    in_t p;
    write_min_len(1024);
    for (int c = 0; c < 1030; c++) begin
      p.pixel = 8'hff;
      p.column = COL_W'(c);
      p.row_index = ROW_W'(20);
      p.row_end = (c == 1029);
      p.frame_start = (c == 0);
      send_pixel(p);
    end
  endtask

  // Lane-like frames: drifting runs row after row, plus random noise pixels.
  task automatic test_random_frames();
    in_t p;
    int unsigned row, x, l, w, total;
    total = 0;
    while (total < 400) begin
      if ($urandom_range(0, 3) == 0) write_min_len($urandom_range(1, 6));
      x = $urandom_range(0, 1000);
      l = $urandom_range(1, 12);
      for (row = 0; row < $urandom_range(4, 12); row++) begin
        w = $urandom_range(l + 2, l + 10);
        if (x + w > 1023) x = 1023 - w;
        send_row($urandom_range(0, 1023), x, x + w, x + 1, l, row == 0);
        total += w + 1;
        x = x + $urandom_range(0, 2) - (x > 0 ? $urandom_range(0, 1) : 0);
      end
      repeat ($urandom_range(5, 30)) begin
        p = in_t'($bits(in_t)'($urandom()));
        if ($urandom_range(0, 3) != 0) p.frame_start = 1'b0;
        send_pixel(p);
        total++;
      end
    end
  endtask

  // The receiver holds off while runs keep coming, so the block backs up.
  task automatic test_backpressure();
    write_min_len(1);
    hold_off = 1'b1;
    fork
      begin
        repeat (400) @(negedge clk);
        hold_off = 1'b0;
      end
      for (int k = 0; k < 12; k++) send_row(30 + k, 0, 7, k % 4, 2, k == 0);
    join
  endtask

  initial begin
    int guard;
    min_len = 10;
    pr_active = 0; pr_start = 0; pr_len = 0;
    clear_tracks();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_table_full();
    test_long_run();
    test_backpressure();
    test_random_frames();
    in_valid <= 1'b0;
    guard = 0;
    while (segments_due.size() != 0 && guard < 50000) begin
      @(negedge clk); guard++;
    end
    repeat (60) @(negedge clk);
    if (segments_due.size() != 0) n_errors++;
    $display("%0d pixels sent, %0d segments checked (%0d with a full table), %0d errors",
             n_pixels, n_segments, n_full, n_errors);
    if (n_errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
